// ===== design/rgc_pkg.sv =====
package rgc_pkg;

  // payload widths
  localparam int LAT_W = 24;
  localparam int LON_W = 25;
  localparam int SEG_W = 23;
  localparam int TOT_W = 40;

  // CORDIC
  localparam int CORDIC_STEPS_DEF = 30;
  localparam int ATAN_SLOTS       = 40;
  localparam int ATAN_IDX_W       = 6;
  localparam int CW               = 34;

  typedef logic signed [CW-1:0] cval_t;

  localparam cval_t INV_GAIN_Q30 = 34'sd652032874;
  localparam cval_t HALF_PI_Q30  = 34'sd1686629713;
  localparam cval_t ONE_Q30      = 34'sd1073741824;

  // angles in degrees * 65536, wide enough for a longitude difference
  localparam int ANG_W = 27;
  localparam int MAG_W = 23;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t FULL_TURN    = 27'sd23592960;
  localparam ang_t HALF_TURN    = 27'sd11796480;
  localparam ang_t QUARTER_TURN = 27'sd5898240;

  // 2*pi in Q30, radius in 1/256 km scaled by 2^8
  localparam logic [CW-1:0] TWO_PI_Q30 = 34'd6746518852;
  localparam logic [CW-1:0] RADIUS_Q8  = 34'd418014036;

  // divide by 45 by reciprocal multiply (full turn is 45 * 2^19)
  localparam int               DIV_N_W   = 37;
  localparam int               DIV_Q_W   = 32;
  localparam int               DIV_BY    = 45;
  localparam int               DIV_SHIFT = 19;
  // dividend bits dropped before the multiply, reciprocal floor(2^38 / 45)
  localparam int               RCP_PRE   = 6;
  localparam int               RCP_W     = 33;
  localparam logic [RCP_W-1:0] RCP_45    = 33'd6108397932;
  localparam int               RCP_SHIFT = 32;

  // integer square root of a Q60 value
  localparam int SQ_W     = 61;
  localparam int ROOT_W   = 31;
  localparam int SQ_IDX_W = 5;
  localparam int SQ_STEPS = 31;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctl_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic cval_t atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    cval_t v;
    v = '0;
    case (idx)
      6'd0: v = 34'sd843314857;
      6'd1: v = 34'sd497837829;
      6'd2: v = 34'sd263043837;
      6'd3: v = 34'sd133525159;
      6'd4: v = 34'sd67021687;
      6'd5: v = 34'sd33543516;
      6'd6: v = 34'sd16775851;
      6'd7: v = 34'sd8388437;
      6'd8: v = 34'sd4194283;
      6'd9: v = 34'sd2097149;
      default: begin
        if (idx <= 6'd30) begin
          v = 34'sd1 <<< (6'd30 - idx);
        end else if (idx == 6'd31) begin
          v = 34'sd1;
        end else begin
          v = '0;
        end
      end
    endcase
    return v;
  endfunction

endpackage

// ===== design/rgc_if.sv =====
interface rgc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rgc_pkg::LAT_W-1:0]   latitude;
  logic signed [rgc_pkg::LON_W-1:0]   longitude;
  logic                               route_end;

  modport source (output valid, latitude, longitude, route_end, input ready);
  modport sink   (input valid, latitude, longitude, route_end, output ready);
endinterface

interface rgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgc_pkg::SEG_W-1:0]   segment_distance;
  logic [rgc_pkg::TOT_W-1:0]   route_total;
  logic                        route_done;

  modport source (output valid, segment_distance, route_total, route_done, input ready);
  modport sink   (input valid, segment_distance, route_total, route_done, output ready);
endinterface

// ===== design/rgc_div45.sv =====
module rgc_div45 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rgc_pkg::DIV_N_W-1:0]   n_in,
  output logic [rgc_pkg::DIV_Q_W-1:0]   q_out,
  output logic                          done
);
  import rgc_pkg::*;

  typedef enum logic [1:0] {PH_MUL, PH_TAKE, PH_FIX} phase_t;

  logic [DIV_N_W-1:0]   n_r;
  logic [63:0]          p_r;
  logic [DIV_Q_W-1:0]   q0_r;
  logic [DIV_Q_W-1:0]   q_r;
  phase_t               ph_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_N_W:0]     q0x45;
  logic [DIV_N_W:0]     rem;
  logic [1:0]           adj;

  // estimate is low by at most two; fix it up from the remainder
  always_comb begin
    q0x45 = ((DIV_N_W+1)'(q0_r) << 5) + ((DIV_N_W+1)'(q0_r) << 3)
          + ((DIV_N_W+1)'(q0_r) << 2) + (DIV_N_W+1)'(q0_r);
    rem   = {1'b0, n_r} - q0x45;
    if (rem >= (DIV_N_W+1)'(3 * DIV_BY)) begin
      adj = 2'd3;
    end else if (rem >= (DIV_N_W+1)'(2 * DIV_BY)) begin
      adj = 2'd2;
    end else if (rem >= (DIV_N_W+1)'(DIV_BY)) begin
      adj = 2'd1;
    end else begin
      adj = 2'd0;
    end
  end

  // multiply by reciprocal, take high bits, correct
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_MUL;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= n_in;
        ph_r   <= PH_MUL;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        case (ph_r)
          PH_MUL: begin
            p_r  <= 64'(n_r[DIV_N_W-1:RCP_PRE]) * 64'(RCP_45);
            ph_r <= PH_TAKE;
          end
          PH_TAKE: begin
            q0_r <= p_r[RCP_SHIFT +: DIV_Q_W];
            ph_r <= PH_FIX;
          end
          default: begin
            q_r    <= q0_r + DIV_Q_W'(adj);
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  assign q_out = q_r;
  assign done  = done_r;

`ifndef SYNTH
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
`endif

endmodule

// ===== design/rgc_isqrt.sv =====
module rgc_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rgc_pkg::SQ_W-1:0]     v_in,
  output logic [rgc_pkg::ROOT_W-1:0]   root,
  output logic                         done
);
  import rgc_pkg::*;

  logic [SQ_W-1:0]     v_r;
  logic [SQ_W:0]       res_r;
  logic [SQ_IDX_W-1:0] j_r;
  logic                busy_r;
  logic                done_r;
  logic [SQ_W:0]       bitv;
  logic [SQ_W:0]       trial;
  logic                fits;

  // digit-by-digit root, bit = 4^j
  always_comb begin
    bitv  = (SQ_W+1)'(1) << {j_r, 1'b0};
    trial = res_r + bitv;
    fits  = ({1'b0, v_r} >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= v_in;
        res_r  <= '0;
        j_r    <= SQ_IDX_W'(SQ_STEPS - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          v_r   <= v_r - trial[SQ_W-1:0];
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        j_r <= j_r - 1'b1;
        if (j_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = res_r[ROOT_W-1:0];
  assign done = done_r;

`ifndef SYNTH
  a_sqrt_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("square root restarted while busy");
`endif

endmodule

// ===== design/rgc_cordic.sv =====
module rgc_cordic #(
  parameter int CORDIC_STEPS = rgc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgc_pkg::cordic_ctl_t ctl,
  input  rgc_pkg::cval_t       x_in,
  input  rgc_pkg::cval_t       y_in,
  input  rgc_pkg::cval_t       z_in,
  output rgc_pkg::cval_t       x_out,
  output rgc_pkg::cval_t       y_out,
  output rgc_pkg::cval_t       z_out,
  output logic                 done
);
  import rgc_pkg::*;

  localparam int StepsUsed = (CORDIC_STEPS > ATAN_SLOTS) ? ATAN_SLOTS : CORDIC_STEPS;
  localparam logic [ATAN_IDX_W-1:0] LastIdx = ATAN_IDX_W'(StepsUsed - 1);

  cval_t                 x_r, y_r, z_r;
  logic [ATAN_IDX_W-1:0] idx_r;
  logic                  rot_r;
  logic                  busy_r;
  logic                  done_r;
  cval_t                 xs, ys, at;
  logic                  dir;

  // one micro-rotation per cycle; dir=1 turns toward +z
  always_comb begin
    xs  = x_r >>> idx_r;
    ys  = y_r >>> idx_r;
    at  = atan_q30(idx_r);
    dir = rot_r ? !z_r[CW-1] : y_r[CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        x_r    <= x_in;
        y_r    <= y_in;
        z_r    <= z_in;
        rot_r  <= ctl.rotate;
        idx_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (dir) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        idx_r <= idx_r + 1'b1;
        if (idx_r == LastIdx) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign done  = done_r;

`ifndef SYNTH
  a_cordic_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("CORDIC restarted while busy");
  a_cordic_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("CORDIC done while still iterating");
`endif

endmodule

// ===== design/route_great_circle_length.sv =====
// Route length accumulator. Each input beat is a waypoint (latitude, longitude in
// 1/65536 degree); each waypoint yields one output beat with the great-circle distance
// from the previous waypoint (1/256 km, law of cosines, R = 6378.388 km), the saturating
// route total, and route_done echoing route_end, after which the route state clears.
// One waypoint is processed at a time and in_ready is high only between waypoints.
// A first waypoint, or one identical to the previous, goes straight to the finish state
// with a zero distance. Any other waypoint runs three sine/cosine passes (angle reduction,
// radian scaling multiply, a reciprocal divide by 45, then a run of CORDIC_STEPS, capped
// at 40, micro-rotations on the shared CORDIC unit), the products and clamping, a square
// root, one vectoring CORDIC run for the arccosine, the radius multiply and the finish
// state. Products other than the divide share one registered multiplier. A finished
// result waits in the output register while the next waypoint is accepted; a new
// result enters that register only once it is free.
module route_great_circle_length #(
  parameter int CORDIC_STEPS = rgc_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rgc_in_if.sink          in_chan,
  rgc_out_if.source       out_chan
);
  import rgc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A_RED, ST_A_MUL, ST_A_DIV, ST_A_DWAIT, ST_A_CWAIT,
    ST_P_CC, ST_P_SS, ST_P_CD, ST_P_SUM, ST_P_SQ, ST_P_SQRT, ST_P_SWAIT,
    ST_P_VWAIT, ST_P_RMUL, ST_P_DIST, ST_FINISH
  } state_t;

  state_t state_r;

  // route state
  logic signed [LAT_W-1:0] prev_lat_r, cur_lat_r;
  logic signed [LON_W-1:0] prev_lon_r, cur_lon_r;
  logic                    have_prev_r;
  logic                    last_r;
  logic [TOT_W-1:0]        total_r;

  // working registers
  logic [1:0]              k_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    zneg_r, cneg_r;
  cval_t                   s_r [3];
  cval_t                   c_r [3];
  cval_t                   cc_r, dot_r, acos_r;
  logic signed [63:0]      acc_r, prod_r;
  logic [SEG_W-1:0]        seg_r;

  // output register
  logic                    out_valid_r;
  logic [SEG_W-1:0]        out_seg_r;
  logic [TOT_W-1:0]        out_tot_r;
  logic                    out_done_r;

  // combinational
  ang_t                    a_sel, r0, r1, r2, mag;
  logic signed [25:0]      dl;
  logic                    fold_neg;
  cval_t                   mul_a, mul_b;
  logic signed [67:0]      prod_full;
  logic [63:0]             n_wide;
  logic [DIV_N_W-1:0]      div_n;
  logic                    div_start, div_done;
  logic [DIV_Q_W-1:0]      div_q;
  cval_t                   zq;
  logic                    sq_start, sq_done;
  logic [SQ_W-1:0]         sq_v;
  logic [ROOT_W-1:0]       root;
  cordic_ctl_t             cctl;
  cval_t                   cx_in, cy_in, cz_in, cx, cy, cz;
  logic                    c_done;
  logic signed [65:0]      dot_sum;
  logic signed [35:0]      dot_raw;
  cval_t                   acos_raw;
  logic [63:0]             dist_wide;
  logic [TOT_W:0]          tot_sum;
  logic [TOT_W-1:0]        tot_new;
  logic                    in_beat, fin_go;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat       = in_chan.valid && (state_r == ST_IDLE);
  assign fin_go        = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  // angle select, reduction to (-180,180] and fold to [-90,90]
  always_comb begin
    dl = 26'(cur_lon_r) - 26'(prev_lon_r);
    case (k_r)
      2'd0:    a_sel = ang_t'(prev_lat_r);
      2'd1:    a_sel = ang_t'(cur_lat_r);
      default: a_sel = dl[25] ? -ang_t'(dl) : ang_t'(dl);
    endcase
    if (a_sel < 0) begin
      r0 = a_sel + FULL_TURN;
    end else if (a_sel >= FULL_TURN) begin
      r0 = a_sel - FULL_TURN;
    end else begin
      r0 = a_sel;
    end
    r1 = (r0 > HALF_TURN) ? r0 - FULL_TURN : r0;
    fold_neg = 1'b0;
    r2 = r1;
    if (r1 > QUARTER_TURN) begin
      r2 = HALF_TURN - r1;
      fold_neg = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2 = -HALF_TURN - r1;
      fold_neg = 1'b1;
    end
    mag = r2[ANG_W-1] ? -r2 : r2;
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_A_MUL:  begin mul_a = cval_t'({1'b0, mag_r}); mul_b = cval_t'(TWO_PI_Q30); end
      ST_P_CC:   begin mul_a = c_r[0];                 mul_b = c_r[1];             end
      ST_P_SS:   begin mul_a = s_r[0];                 mul_b = s_r[1];             end
      ST_P_CD:   begin mul_a = cc_r;                   mul_b = c_r[2];             end
      ST_P_SQ:   begin mul_a = dot_r;                  mul_b = dot_r;              end
      ST_P_RMUL: begin mul_a = acos_r;                 mul_b = cval_t'(RADIUS_Q8); end
      default:   begin mul_a = '0;                     mul_b = '0;                 end
    endcase
    prod_full = mul_a * mul_b;
  end

  // radian scaling: (mag*2pi + half turn) / (45 * 2^19)
  always_comb begin
    n_wide    = 64'(prod_r) + 64'(HALF_TURN);
    div_n     = n_wide[DIV_SHIFT +: DIV_N_W];
    div_start = (state_r == ST_A_DIV);
    zq        = cval_t'({1'b0, div_q});
  end

  // dot product rounding, sqrt operand clamp, arccosine, distance scaling, saturated total
  always_comb begin
    dot_sum   = 66'(acc_r) + 66'(prod_r) + 66'sd536870912;
    dot_raw   = 36'(dot_sum >>> 30);
    sq_start  = (state_r == ST_P_SQRT);
    sq_v      = (prod_r >= 64'sh1000_0000_0000_0000) ? '0
                : SQ_W'(64'sh1000_0000_0000_0000 - prod_r);
    acos_raw  = cz + HALF_PI_Q30;
    dist_wide = 64'(prod_r) + 64'h20_0000_0000;
    tot_sum   = {1'b0, total_r} + (TOT_W+1)'(seg_r);
    tot_new   = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
  end

  // CORDIC command: rotation for sin/cos, vectoring for arccosine
  always_comb begin
    cctl.start  = 1'b0;
    cctl.rotate = 1'b1;
    cx_in       = INV_GAIN_Q30;
    cy_in       = '0;
    cz_in       = zneg_r ? -zq : zq;
    if (state_r == ST_A_DWAIT && div_done) begin
      cctl.start = 1'b1;
    end else if (state_r == ST_P_SWAIT && sq_done) begin
      cctl.start  = 1'b1;
      cctl.rotate = 1'b0;
      cx_in       = cval_t'({1'b0, root});
      cy_in       = -dot_r;
      cz_in       = '0;
    end
  end

  rgc_div45 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n_in  (div_n),
    .q_out (div_q),
    .done  (div_done)
  );

  rgc_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v_in  (sq_v),
    .root  (root),
    .done  (sq_done)
  );

  rgc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .z_in  (cz_in),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz),
    .done  (c_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      prev_lat_r  <= '0;
      prev_lon_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= prod_full[63:0];
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            cur_lat_r <= in_chan.latitude;
            cur_lon_r <= in_chan.longitude;
            last_r    <= in_chan.route_end;
            k_r       <= 2'd0;
            seg_r     <= '0;
            if (!have_prev_r || (in_chan.latitude == prev_lat_r &&
                                 in_chan.longitude == prev_lon_r)) begin
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_A_RED;
            end
          end
        end
        ST_A_RED: begin
          mag_r   <= mag[MAG_W-1:0];
          zneg_r  <= r2[ANG_W-1];
          cneg_r  <= fold_neg;
          state_r <= ST_A_MUL;
        end
        ST_A_MUL:   state_r <= ST_A_DIV;
        ST_A_DIV:   state_r <= ST_A_DWAIT;
        ST_A_DWAIT: if (div_done) state_r <= ST_A_CWAIT;
        ST_A_CWAIT: begin
          if (c_done) begin
            s_r[k_r] <= cy;
            c_r[k_r] <= cneg_r ? -cx : cx;
            k_r      <= k_r + 1'b1;
            state_r  <= (k_r == 2'd2) ? ST_P_CC : ST_A_RED;
          end
        end
        ST_P_CC: state_r <= ST_P_SS;
        ST_P_SS: begin
          // prod holds cos1*cos2
          cc_r    <= CW'((prod_r + 64'sd536870912) >>> 30);
          state_r <= ST_P_CD;
        end
        ST_P_CD: begin
          acc_r   <= prod_r;
          state_r <= ST_P_SUM;
        end
        ST_P_SUM: begin
          if (dot_raw > 36'(ONE_Q30)) begin
            dot_r <= ONE_Q30;
          end else if (dot_raw < -36'(ONE_Q30)) begin
            dot_r <= -ONE_Q30;
          end else begin
            dot_r <= CW'(dot_raw);
          end
          state_r <= ST_P_SQ;
        end
        ST_P_SQ:    state_r <= ST_P_SQRT;
        ST_P_SQRT:  state_r <= ST_P_SWAIT;
        ST_P_SWAIT: if (sq_done) state_r <= ST_P_VWAIT;
        ST_P_VWAIT: begin
          if (c_done) begin
            acos_r  <= acos_raw[CW-1] ? '0 : acos_raw;
            state_r <= ST_P_RMUL;
          end
        end
        ST_P_RMUL: state_r <= ST_P_DIST;
        ST_P_DIST: begin
          seg_r   <= dist_wide[38 +: SEG_W];
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_seg_r   <= seg_r;
            out_tot_r   <= tot_new;
            out_done_r  <= last_r;
            if (last_r) begin
              have_prev_r <= 1'b0;
              prev_lat_r  <= '0;
              prev_lon_r  <= '0;
              total_r     <= '0;
            end else begin
              have_prev_r <= 1'b1;
              prev_lat_r  <= cur_lat_r;
              prev_lon_r  <= cur_lon_r;
              total_r     <= tot_new;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.segment_distance = out_seg_r;
  assign out_chan.route_total      = out_tot_r;
  assign out_chan.route_done       = out_done_r;

`ifndef SYNTH
  a_route_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && last_r) |=> (!have_prev_r && total_r == '0 && out_valid_r &&
                            out_chan.route_done))
    else $error("route state not cleared at route end");
  a_total_covers_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tot_r >= TOT_W'(out_seg_r)))
    else $error("route total below segment distance");
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && !have_prev_r) |=> (state_r == ST_FINISH && seg_r == '0))
    else $error("first waypoint did not give zero distance");
`endif

endmodule
